// ===== rtl/core/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Holds register indexes, reset values and the flag and event structs.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // configuration register widths and indexes
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] RegDebounce    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegDoubleClick = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegLongPress   = 2'd2;

  // register reset values in ticks
  localparam logic [CfgWidth-1:0] DebounceReset    = 16'd50;
  localparam logic [CfgWidth-1:0] DoubleClickReset = 16'd500;
  localparam logic [CfgWidth-1:0] LongPressReset   = 16'd1000;

  // level codes of the active-low button
  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  // classifier flags carried from tick to tick
  typedef struct packed {
    logic stable_level;
    logic last_sample;
    logic click_pending;
    logic wait_double;
    logic long_handled;
    logic long_active;
  } flags_t;

  localparam flags_t FlagsReset = '{
    stable_level:  LevelReleased,
    last_sample:   LevelReleased,
    click_pending: 1'b0,
    wait_double:   1'b0,
    long_handled:  1'b0,
    long_active:   1'b0
  };

  // events and status of one tick
  typedef struct packed {
    logic is_pressed;
    logic long_press_event;
    logic double_click_event;
    logic click_event;
  } events_t;

endpackage

// ===== rtl/core/bcc_step.sv =====
// ----------------------------------------------------------------------------
// bcc_step: next-state logic of one tick
// Debounce, press classification, long press and click confirmation.
// ----------------------------------------------------------------------------
module bcc_step #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                           sample_i,
  input  bcc_pkg::flags_t                flags_i,
  input  logic [TIMER_WIDTH-1:0]         deb_elapsed_i,
  input  logic [TIMER_WIDTH-1:0]         press_elapsed_i,
  input  logic [bcc_pkg::CfgWidth-1:0]   debounce_ms_i,
  input  logic [bcc_pkg::CfgWidth-1:0]   double_click_ms_i,
  input  logic [bcc_pkg::CfgWidth-1:0]   long_press_ms_i,
  output bcc_pkg::flags_t                flags_o,
  output logic [TIMER_WIDTH-1:0]         deb_elapsed_o,
  output logic [TIMER_WIDTH-1:0]         press_elapsed_o,
  output bcc_pkg::events_t               events_o
);

  localparam int unsigned CmpW =
    (TIMER_WIDTH > bcc_pkg::CfgWidth) ? TIMER_WIDTH : bcc_pkg::CfgWidth;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  logic [TIMER_WIDTH-1:0] deb_inc, press_inc;
  logic [CmpW-1:0]        deb_x, press_inc_x, press_fin_x;
  logic [CmpW-1:0]        deb_ms_x, dbl_ms_x, long_ms_x;
  logic                   accept_level;
  bcc_pkg::flags_t        f;
  bcc_pkg::events_t       ev;
  logic [TIMER_WIDTH-1:0] press_fin;

  // saturating tick counters, raw change restarts debounce
  assign deb_inc   = (deb_elapsed_i == TimerMax) ? TimerMax : deb_elapsed_i + 1'b1;
  assign press_inc = (press_elapsed_i == TimerMax) ? TimerMax : press_elapsed_i + 1'b1;

  assign deb_x       = (sample_i != flags_i.last_sample) ? '0 : CmpW'(deb_inc);
  assign press_inc_x = CmpW'(press_inc);
  assign deb_ms_x    = CmpW'(debounce_ms_i);
  assign dbl_ms_x    = CmpW'(double_click_ms_i);
  assign long_ms_x   = CmpW'(long_press_ms_i);

  assign accept_level = (deb_x > deb_ms_x) && (sample_i != flags_i.stable_level);

  // classification in the order of one tick
  always_comb begin
    f         = flags_i;
    ev        = '0;
    press_fin = press_inc;

    // debounced level and press handling
    if (accept_level) begin
      f.stable_level = sample_i;
      if (sample_i == bcc_pkg::LevelPressed) begin
        if (flags_i.wait_double && (press_inc_x < dbl_ms_x)) begin
          ev.double_click_event = 1'b1;
          f.wait_double         = 1'b0;
          f.click_pending       = 1'b0;
        end else begin
          f.click_pending = 1'b1;
          f.wait_double   = 1'b1;
          f.long_active   = 1'b1;
        end
        press_fin = '0;
      end
    end

    // long press detection
    if ((f.stable_level == bcc_pkg::LevelPressed) &&
        (CmpW'(press_fin) > long_ms_x) && !f.long_handled) begin
      ev.long_press_event = 1'b1;
      f.long_handled      = 1'b1;
      f.wait_double       = 1'b0;
      f.click_pending     = 1'b0;
      f.long_active       = 1'b0;
    end

    // release handling
    if (f.stable_level == bcc_pkg::LevelReleased) begin
      f.long_handled = 1'b0;
      f.long_active  = 1'b0;
    end

    f.last_sample = sample_i;

    // single click confirmation
    if (f.click_pending && !f.long_active && (CmpW'(press_fin) > dbl_ms_x)) begin
      ev.click_event  = 1'b1;
      f.click_pending = 1'b0;
      f.wait_double   = 1'b0;
    end

    ev.is_pressed = (f.stable_level == bcc_pkg::LevelPressed);
  end

  assign press_fin_x     = CmpW'(press_fin);
  assign flags_o         = f;
  assign events_o        = ev;
  assign deb_elapsed_o   = deb_x[TIMER_WIDTH-1:0];
  assign press_elapsed_o = press_fin_x[TIMER_WIDTH-1:0];

endmodule

// ===== rtl/core/button_click_classifier.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier: debounced click, double click and long press
// One tick word in, one event word out; state updates on each accepted tick.
// ----------------------------------------------------------------------------
//  channel   dir  fields (lsb first)                               handshake
//  s_axis    in   tdata: pin_level                                 tvalid/tready
//  m_axis    out  tdata: click, double_click, long_press, pressed  tvalid/tready
//  cfg       in   cfg_idx_i, cfg_wdata_i                           cfg_we_i
//
//  one tick word per cycle while the sink keeps up; its event word shows in the
//  output register in the cycle after acceptance
//  s_axis_tready is high when the output register is empty or being taken,
//  so ticks stream back to back while the sink keeps up
//  reset restores the default thresholds and clears all counters and flags
//  a stalled sink holds the output word and stalls the input side
// ----------------------------------------------------------------------------
module button_click_classifier #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [0] pin_level
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] click_event [1] double_click_event [2] long_press_event [3] is_pressed
  output logic [7:0]                        m_axis_tdata
);

  logic [bcc_pkg::CfgWidth-1:0] debounce_ms_q, double_click_ms_q, long_press_ms_q;
  bcc_pkg::flags_t              flags_q, flags_d;
  logic [TIMER_WIDTH-1:0]       deb_elapsed_q, deb_elapsed_d;
  logic [TIMER_WIDTH-1:0]       press_elapsed_q, press_elapsed_d;
  bcc_pkg::events_t             events_d, out_q;
  logic                         out_valid_q;
  logic                         in_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q     <= bcc_pkg::DebounceReset;
      double_click_ms_q <= bcc_pkg::DoubleClickReset;
      long_press_ms_q   <= bcc_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcc_pkg::RegDebounce:    debounce_ms_q     <= cfg_wdata_i;
        bcc_pkg::RegDoubleClick: double_click_ms_q <= cfg_wdata_i;
        bcc_pkg::RegLongPress:   long_press_ms_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // tick handshake
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  bcc_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .sample_i          (s_axis_tdata[0]),
    .flags_i           (flags_q),
    .deb_elapsed_i     (deb_elapsed_q),
    .press_elapsed_i   (press_elapsed_q),
    .debounce_ms_i     (debounce_ms_q),
    .double_click_ms_i (double_click_ms_q),
    .long_press_ms_i   (long_press_ms_q),
    .flags_o           (flags_d),
    .deb_elapsed_o     (deb_elapsed_d),
    .press_elapsed_o   (press_elapsed_d),
    .events_o          (events_d)
  );

  // classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q         <= bcc_pkg::FlagsReset;
      deb_elapsed_q   <= '0;
      press_elapsed_q <= '0;
    end else if (in_fire) begin
      flags_q         <= flags_d;
      deb_elapsed_q   <= deb_elapsed_d;
      press_elapsed_q <= press_elapsed_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= events_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  // at most one event per word
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({out_q.click_event, out_q.double_click_event,
                                out_q.long_press_event}))
    else $error("more than one event in a word");

  // long press and double click only while pressed
  a_long_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.long_press_event || out_q.double_click_event))
      |-> out_q.is_pressed)
    else $error("press event while released");

  // pressed status in the word matches the debounced level
  a_level_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_q.is_pressed == (flags_q.stable_level == bcc_pkg::LevelPressed)))
    else $error("status does not match debounced level");

  // a pending click is never left while a long press is being held
  a_long_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.long_handled |-> !flags_q.click_pending)
    else $error("click pending after long press");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the button click classifier
// Streams millisecond tick words through the block under random stalls on
// both sides, predicts each event word from a local copy of the classifier
// state, and compares the event words as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned CfgW = bcc_pkg::CfgWidth;
  localparam logic [TimerWidth-1:0] TimerMax = '1;
  localparam logic [bcc_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 8;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [bcc_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]                 cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;  // [0] pin_level
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] click_event [1] double_click_event [2] long_press_event [3] is_pressed
  logic [7:0]                      m_axis_tdata;

  button_click_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // thresholds as the block holds them
  logic [CfgW-1:0] thr_debounce = bcc_pkg::DebounceReset;
  logic [CfgW-1:0] thr_double   = bcc_pkg::DoubleClickReset;
  logic [CfgW-1:0] thr_long     = bcc_pkg::LongPressReset;

  // classifier state as the block holds it
  logic                  lvl_stable    = bcc_pkg::LevelReleased;
  logic                  lvl_last      = bcc_pkg::LevelReleased;
  logic [TimerWidth-1:0] settle_ticks  = '0;
  logic [TimerWidth-1:0] hold_ticks    = '0;
  logic                  single_armed  = 1'b0;
  logic                  double_window = 1'b0;
  logic                  long_done     = 1'b0;
  logic                  long_live     = 1'b0;

  bcc_pkg::events_t expected_events[$];

  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned words_seen = 0;
  int unsigned clicks_seen = 0;
  int unsigned doubles_seen = 0;
  int unsigned longs_seen = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;  // no idling on either side while set

  function automatic logic [TimerWidth-1:0] bump(input logic [TimerWidth-1:0] v);
    return (v == TimerMax) ? v : v + 1'b1;
  endfunction

  // one tick of the classifier: updates the local state, returns the event word
  function automatic bcc_pkg::events_t classify_tick(input logic pin);
    bcc_pkg::events_t ev;
    ev = '0;
    settle_ticks = bump(settle_ticks);
    hold_ticks   = bump(hold_ticks);
    if (pin != lvl_last) settle_ticks = '0;

    // debounced level change and press classification
    if (settle_ticks > thr_debounce && pin != lvl_stable) begin
      lvl_stable = pin;
      if (lvl_stable == bcc_pkg::LevelPressed) begin
        if (double_window && hold_ticks < thr_double) begin
          ev.double_click_event = 1'b1;
          double_window = 1'b0;
          single_armed  = 1'b0;
        end else begin
          single_armed  = 1'b1;
          double_window = 1'b1;
          long_live     = 1'b1;
        end
        hold_ticks = '0;
      end
    end

    // long press, once per hold
    if (lvl_stable == bcc_pkg::LevelPressed && hold_ticks > thr_long && !long_done) begin
      ev.long_press_event = 1'b1;
      long_done     = 1'b1;
      double_window = 1'b0;
      single_armed  = 1'b0;
      long_live     = 1'b0;
    end

    if (lvl_stable == bcc_pkg::LevelReleased) begin
      long_done = 1'b0;
      long_live = 1'b0;
    end

    lvl_last = pin;

    // single click once the double window has run out
    if (single_armed && !long_live && hold_ticks > thr_double) begin
      ev.click_event = 1'b1;
      single_armed  = 1'b0;
      double_window = 1'b0;
    end

    ev.is_pressed = (lvl_stable == bcc_pkg::LevelPressed);
    return ev;
  endfunction

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 16);
    return 0;
  endfunction

  // send one tick word; entered and left at a falling edge
  task automatic send_tick(input logic pin);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, pin};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_events.push_back(classify_tick(pin));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic pin, input int unsigned n);
    repeat (n) send_tick(pin);
  endtask

  // hold off the sender until every predicted word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // write all thresholds while the block is idle, plus the unused index
  task automatic set_thresholds(input logic [CfgW-1:0] deb,
                                input logic [CfgW-1:0] dbl,
                                input logic [CfgW-1:0] lng);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bcc_pkg::RegDebounce;
    cfg_wdata_i <= deb;
    @(negedge clk_i);
    cfg_idx_i   <= bcc_pkg::RegDoubleClick;
    cfg_wdata_i <= dbl;
    @(negedge clk_i);
    cfg_idx_i   <= bcc_pkg::RegLongPress;
    cfg_wdata_i <= lng;
    @(negedge clk_i);
    cfg_idx_i   <= RegUnused;
    cfg_wdata_i <= CfgW'($urandom_range(0, 65535));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_debounce = deb;
    thr_double   = dbl;
    thr_long     = lng;
    @(negedge clk_i);
  endtask

  // default thresholds straight after reset: nothing is accepted this soon
  task automatic test_reset_values();
    send_run(bcc_pkg::LevelPressed, 3);
    send_tick(bcc_pkg::LevelReleased);
  endtask

  // zero thresholds: one steady tick accepts, no double click ever
  task automatic test_zero_thresholds();
    set_thresholds('0, '0, '0);
    send_run(bcc_pkg::LevelPressed, 2);
    send_run(bcc_pkg::LevelReleased, 2);
    send_run(bcc_pkg::LevelPressed, 3);
    send_run(bcc_pkg::LevelReleased, 2);
  endtask

  // largest thresholds: no level is ever accepted
  task automatic test_max_thresholds();
    set_thresholds('1, '1, '1);
    send_run(bcc_pkg::LevelPressed, 3);
    send_tick(bcc_pkg::LevelReleased);
    send_run(bcc_pkg::LevelPressed, 2);
  endtask

  // double click that must also cancel the pending single click
  task automatic test_double_cancels_click();
    set_thresholds(16'd0, 16'd5, 16'd20);
    send_run(bcc_pkg::LevelReleased, 2);
    send_run(bcc_pkg::LevelPressed, 2);
    send_run(bcc_pkg::LevelReleased, 2);
    send_run(bcc_pkg::LevelPressed, 2);
    send_run(bcc_pkg::LevelReleased, 8);
  endtask

  // alternating runs around the current thresholds, with glitches
  task automatic random_gestures(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned span;
    int unsigned dd;
    logic        level;
    sent  = 0;
    level = 1'($urandom_range(0, 1));
    dd    = (thr_debounce > 40) ? 40 : thr_debounce;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0:       span = 3;
        1:       span = ((thr_double > 40) ? 40 : thr_double) + 3;
        default: span = ((thr_long > 40) ? 40 : thr_long) + 3;
      endcase
      if ($urandom_range(0, 99) < 15) len = $urandom_range(1, dd + 1);
      else len = dd + 1 + $urandom_range(0, span);
      send_run(level, len);
      sent += len;
      level = ~level;
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  task automatic test_random_phases();
    set_thresholds(16'd0, 16'd0, 16'd0);
    random_gestures(140);
    set_thresholds(16'd1, 16'd4, 16'd10);
    random_gestures(140);
    // long press window shorter than the double window
    set_thresholds(16'd2, 16'd8, 16'd6);
    random_gestures(140);
    set_thresholds(16'd0, TimerMax, 16'd12);
    random_gestures(140);
    steady = 1'b1;
    set_thresholds(16'd1, 16'd6, TimerMax);
    random_gestures(140);
    steady = 1'b0;
    set_thresholds(16'd3, 16'd12, 16'd25);
    random_gestures(140);
    set_thresholds(TimerMax, 16'd5, 16'd5);
    random_gestures(60);
    repeat (2) begin
      set_thresholds(CfgW'($urandom_range(0, 3)), CfgW'($urandom_range(0, 15)),
                     CfgW'($urandom_range(0, 30)));
      random_gestures(180);
    end
  endtask

  // sink side: random stalls between words
  initial begin : sink_driver
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // compare each event word with the oldest prediction
  always @(posedge clk_i) begin : check_events
    bcc_pkg::events_t got;
    bcc_pkg::events_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bcc_pkg::events_t'(m_axis_tdata[3:0]);
      words_seen++;
      clicks_seen  += got.click_event;
      doubles_seen += got.double_click_event;
      longs_seen   += got.long_press_event;
      if (expected_events.size() == 0) begin
        $error("event word %h with no tick waiting", m_axis_tdata);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (got.click_event !== want.click_event) begin
          $error("click_event expected %0b actual %0b", want.click_event, got.click_event);
          errors++;
        end
        if (got.double_click_event !== want.double_click_event) begin
          $error("double_click_event expected %0b actual %0b",
                 want.double_click_event, got.double_click_event);
          errors++;
        end
        if (got.long_press_event !== want.long_press_event) begin
          $error("long_press_event expected %0b actual %0b",
                 want.long_press_event, got.long_press_event);
          errors++;
        end
        if (got.is_pressed !== want.is_pressed) begin
          $error("is_pressed expected %0b actual %0b", want.is_pressed, got.is_pressed);
          errors++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_events.size());
      $display("button_click_classifier test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_zero_thresholds();
    test_max_thresholds();
    test_double_cancels_click();
    test_random_phases();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("sent %0d ticks under reset defaults, zero, max and random thresholds",
             ticks_sent);
    $display("checked %0d event words: %0d clicks, %0d double clicks, %0d long presses",
             words_seen, clicks_seen, doubles_seen, longs_seen);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("button_click_classifier test passed");
    end else begin
      $display("button_click_classifier test failed");
    end
    $finish;
  end

endmodule
